### rtl/core/rcem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcem_pkg;

  // stream and register field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned ROOT_STEPS = 8;
  localparam int unsigned STEP_W     = 3;

  localparam logic [PIX_W-1:0] CLIP_MAX = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // result slots, in the order they leave the block
  localparam int unsigned RES_EDGE  = 0;
  localparam int unsigned RES_RIGHT = 1;
  localparam int unsigned RES_LOWER = 2;
  localparam int unsigned RES_NUM   = 3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;       // accept the offered pixel
    logic square;     // gradients, squares and line store write
    logic root_step;  // one digit of the square root
    logic emit;       // load the next pending result into the output register
  } rcem_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_root;  // an edge result is pending
    logic root_last;  // final root digit is being made
    logic pend_any;   // at least one result still to send
    logic pend_last;  // exactly one result still to send
    logic out_free;   // output register can take a result this cycle
  } rcem_sts_t;

endpackage

`default_nettype wire

### rtl/core/rcem_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rcem_ctrl
  import rcem_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rcem_sts_t sts_i,
  output rcem_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.square    = (state_q == ST_SQUARE);
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.emit      = (state_q == ST_EMIT) && sts_i.out_free && sts_i.pend_any;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (sts_i.need_root)     state_d = ST_ROOT;
        else if (sts_i.pend_any) state_d = ST_EMIT;
        else                     state_d = ST_IDLE;
      end
      ST_ROOT: begin
        if (sts_i.root_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.pend_any) state_d = ST_IDLE;
        else if (cmd_o.emit && sts_i.pend_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rcem_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rcem_datapath
  import rcem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rcem_cmd_t             cmd_i,
  output rcem_sts_t                  sts_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  cfg_write_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [PIX_W-1:0]           out_pixel_o,
  output logic [COORD_W-1:0]         out_x_o,
  output logic [COORD_W-1:0]         out_y_o,
  output logic                       out_is_edge_o,
  output logic                       out_last_o,
  output logic                       out_frame_end_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_RST  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int unsigned HEIGHT_RST = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;
  localparam logic [XW-1:0] WLAST_RST = XW'(WIDTH_RST - 1);
  localparam logic [YW-1:0] HLAST_RST = YW'(HEIGHT_RST - 1);
  localparam logic [XW-1:0] WLAST_MAX = XW'(MAX_WIDTH - 1);
  localparam logic [YW-1:0] HLAST_MAX = YW'(MAX_HEIGHT - 1);

  // last column and last row in use, clamped on write
  logic [XW-1:0] wlast_q;
  logic [YW-1:0] hlast_q;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;

  // item being worked on
  logic [XW-1:0]      x_q;
  logic [YW-1:0]      y_q;
  logic [PIX_W-1:0]   d_q;
  logic [PIX_W-1:0]   b_q;
  logic [PIX_W-1:0]   left_q;
  logic [PIX_W-1:0]   upleft_q;
  logic [RES_NUM-1:0] pend_q;
  logic               lastpix_q;

  // square root unit
  logic [2*PIX_W-1:0]  rad_q;
  logic [PIX_W:0]      rem_q;
  logic [PIX_W-1:0]    root_q;
  logic [STEP_W-1:0]   step_q;
  logic                ovf_q;

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];

  // configuration and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= WLAST_RST;
      hlast_q <= HLAST_RST;
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_write_i) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        if (cfg_data_i == '0)                        wlast_q <= '0;
        else if (32'(cfg_data_i) > 32'(MAX_WIDTH))   wlast_q <= WLAST_MAX;
        else                                         wlast_q <= XW'(cfg_data_i - 13'd1);
        col_q <= '0;
        row_q <= '0;
      end else if (cfg_index_i == REG_FRAME_HEIGHT) begin
        if (cfg_data_i == '0)                        hlast_q <= '0;
        else if (32'(cfg_data_i) > 32'(MAX_HEIGHT))  hlast_q <= HLAST_MAX;
        else                                         hlast_q <= YW'(cfg_data_i - 13'd1);
        col_q <= '0;
        row_q <= '0;
      end
    end else if (cmd_i.take) begin
      if (col_q == wlast_q) begin
        col_q <= '0;
        row_q <= (row_q == hlast_q) ? '0 : row_q + YW'(1);
      end else begin
        col_q <= col_q + XW'(1);
      end
    end
  end

  // line store: read at accept, write back while squaring
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      b_q <= row_mem[col_q];
    end
    if (cmd_i.square) begin
      row_mem[x_q] <= d_q;
    end
  end

  // capture of the accepted pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q       <= col_q;
      y_q       <= row_q;
      d_q       <= pixel_i;
      lastpix_q <= (col_q == wlast_q) && (row_q == hlast_q);
    end
  end

  // results still owed for the current pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (cmd_i.take) begin
      pend_q[RES_EDGE]  <= (col_q != '0) && (row_q != '0);
      pend_q[RES_RIGHT] <= (col_q == wlast_q) && (row_q != '0);
      pend_q[RES_LOWER] <= (row_q == hlast_q);
    end else if (cmd_i.emit) begin
      if (pend_q[RES_EDGE])       pend_q[RES_EDGE]  <= 1'b0;
      else if (pend_q[RES_RIGHT]) pend_q[RES_RIGHT] <= 1'b0;
      else                        pend_q[RES_LOWER] <= 1'b0;
    end
  end

  // gradients and their squares
  logic signed [PIX_W:0]     gx, gy;
  logic signed [2*PIX_W+1:0] sqx, sqy;
  logic [SUM_W-1:0]          sum_d;

  always_comb begin
    gx    = $signed({1'b0, upleft_q}) - $signed({1'b0, d_q});
    gy    = $signed({1'b0, b_q}) - $signed({1'b0, left_q});
    sqx   = gx * gx;
    sqy   = gy * gy;
    sum_d = {1'b0, sqx[2*PIX_W-1:0]} + {1'b0, sqy[2*PIX_W-1:0]};
  end

  // neighbor pixels carried to the next column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
    end else if (cmd_i.square) begin
      left_q   <= d_q;
      upleft_q <= b_q;
    end
  end

  // digit-serial floor square root, two radicand bits per step
  logic [PIX_W+2:0] shifted;
  logic [PIX_W+1:0] trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, rad_q[2*PIX_W-1 -: 2]};
    trial   = {root_q, 2'b01};
    fits    = (shifted >= {1'b0, trial});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.square) begin
      step_q <= '0;
    end else if (cmd_i.root_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      rad_q  <= sum_d[2*PIX_W-1:0];
      ovf_q  <= sum_d[SUM_W-1];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[2*PIX_W-3:0], 2'b00};
      root_q <= {root_q[PIX_W-2:0], fits};
      rem_q  <= fits ? (PIX_W+1)'(shifted - {1'b0, trial}) : (PIX_W+1)'(shifted);
    end
  end

  logic [PIX_W-1:0] mag;
  assign mag = ovf_q ? CLIP_MAX : root_q;

  // output register
  logic out_valid_q;
  logic out_free;
  logic [RES_NUM-1:0] pend_rest;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pend_rest = pend_q;
    if (pend_q[RES_EDGE])       pend_rest[RES_EDGE]  = 1'b0;
    else if (pend_q[RES_RIGHT]) pend_rest[RES_RIGHT] = 1'b0;
    else                        pend_rest[RES_LOWER] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_last_o      <= (pend_rest == '0);
      out_frame_end_o <= (pend_rest == '0) && lastpix_q;
      if (pend_q[RES_EDGE]) begin
        out_pixel_o   <= mag;
        out_x_o       <= COORD_W'(x_q - XW'(1));
        out_y_o       <= COORD_W'(y_q - YW'(1));
        out_is_edge_o <= 1'b1;
      end else if (pend_q[RES_RIGHT]) begin
        out_pixel_o   <= b_q;
        out_x_o       <= COORD_W'(x_q);
        out_y_o       <= COORD_W'(y_q - YW'(1));
        out_is_edge_o <= 1'b0;
      end else begin
        out_pixel_o   <= d_q;
        out_x_o       <= COORD_W'(x_q);
        out_y_o       <= COORD_W'(y_q);
        out_is_edge_o <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  always_comb begin
    sts_o           = '0;
    sts_o.need_root = pend_q[RES_EDGE];
    sts_o.root_last = (step_q == STEP_W'(ROOT_STEPS - 1));
    sts_o.pend_any  = (pend_q != '0);
    sts_o.pend_last = $onehot(pend_q);
    sts_o.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_take_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> (pend_q == '0))
    else $error("pixel taken while results of the previous one are owed");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (pend_q != '0) && out_free)
    else $error("result emitted with nothing pending or output busy");

  a_frame_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_frame_end_o) |-> out_last_o)
    else $error("frame end flagged on a result that is not the last of its pixel");

  a_root_done_before_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.root_step && sts_o.root_last) |=> !cmd_i.root_step)
    else $error("square root ran past its final digit");
`endif

endmodule

`default_nettype wire

### rtl/core/roberts_cross_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none

// Roberts cross edge magnitude over a raster-order 8-bit grey stream. The
// previous row sits in a MAX_WIDTH x 8 line store; for pixel (x,y) the block
// sends floor(sqrt(gx^2+gy^2)) clipped at 255 for (x-1,y-1), plus the last
// column and last row unchanged, each result tagged with its column and row.
// One pixel is in flight at a time: each pixel is accepted and squared; a
// pixel with an edge result then runs the 8-step digit-serial square root
// (two radicand bits a cycle); any results are then sent one at a time,
// each waiting for the output register to be free. The output register
// lets the next pixel in while the last result still waits. Writing
// frame_width or frame_height restarts the frame at (0,0); values are
// clamped to 1..MAX.

module roberts_cross_edge_magnitude
  import rcem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] pixel
  // result output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [7:0] out_pixel, [19:8] out_x,
                                                     // [31:20] out_y
  output logic [1:0]                 m_axis_tuser,   // [0] is_edge, [1] frame_end
  output logic                       m_axis_tlast    // last_of_run
);

  rcem_cmd_t cmd;
  rcem_sts_t sts;

  logic [PIX_W-1:0]   res_pixel;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;
  logic               res_edge;
  logic               res_frame_end;

  assign cfg_ready_o = 1'b1;

  rcem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_i         (s_axis_tdata),
    .cfg_write_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_pixel_o     (res_pixel),
    .out_x_o         (res_x),
    .out_y_o         (res_y),
    .out_is_edge_o   (res_edge),
    .out_last_o      (m_axis_tlast),
    .out_frame_end_o (res_frame_end)
  );

  // result packing
  assign m_axis_tdata = {res_y, res_x, res_pixel};
  assign m_axis_tuser = {res_frame_end, res_edge};

endmodule

`default_nettype wire

### tb/tb_roberts_cross_edge_magnitude.sv
`timescale 1ns / 1ps

module tb_roberts_cross_edge_magnitude;
  import rcem_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned RANDOM_PIX  = 320;
  localparam int unsigned EXTREME_PIX = 64;

  // which registers a frame setup writes
  localparam int unsigned WRITE_BOTH   = 0;
  localparam int unsigned WRITE_WIDTH  = 1;
  localparam int unsigned WRITE_HEIGHT = 2;

  typedef struct packed {
    logic [PIX_W-1:0]   out_pixel;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               is_edge;
    logic               last_of_run;
    logic               frame_end;
  } edge_result_t;

  // edge magnitude predictor and store of expected results
  class edge_scoreboard;
    bit [PIX_W-1:0]      line_mem [MAX_DIM];
    int unsigned         col;
    int unsigned         row;
    bit [PIX_W-1:0]      left_pix;
    bit [PIX_W-1:0]      upper_left_pix;
    bit [CFG_DATA_W-1:0] width_reg;
    bit [CFG_DATA_W-1:0] height_reg;
    edge_result_t        expected_q[$];
    int unsigned         errors;

    function new();
      col            = 0;
      row            = 0;
      left_pix       = '0;
      upper_left_pix = '0;
      width_reg      = CFG_DATA_W'(MAX_DIM);
      height_reg     = CFG_DATA_W'(MAX_DIM);
      errors         = 0;
    endfunction

    function int unsigned clamp_dim(bit [CFG_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // a write to frame width or frame height restarts the frame
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = val;
      end else begin
        return;
      end
      col = 0;
      row = 0;
    endfunction

    // bit-by-bit floor square root, sums stay below 2^17
    function int unsigned floor_root(int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int k = 8; k >= 0; k--) begin
        t = r + (1 << k);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function edge_result_t make_result(int unsigned pix, int unsigned x, int unsigned y,
                                       bit is_edge);
      edge_result_t r;
      r.out_pixel   = PIX_W'(pix);
      r.out_x       = COORD_W'(x);
      r.out_y       = COORD_W'(y);
      r.is_edge     = is_edge;
      r.last_of_run = 1'b0;
      r.frame_end   = 1'b0;
      return r;
    endfunction

    // work out the results of one accepted pixel and advance the frame position
    function void note_pixel(logic [PIX_W-1:0] d);
      int unsigned  w, h, x, y, sum, mag;
      int           gx, gy;
      bit [PIX_W-1:0] a, b, c;
      edge_result_t res[$];
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      x = col;
      y = row;
      if (x >= w) x = 0;
      if (y >= h) y = 0;
      a = upper_left_pix;
      b = line_mem[x];
      c = left_pix;
      if (x >= 1 && y >= 1) begin
        gx  = int'(a) - int'(d);
        gy  = int'(b) - int'(c);
        sum = gx * gx + gy * gy;
        mag = floor_root(sum);
        if (mag > CLIP_MAX) mag = CLIP_MAX;
        res.push_back(make_result(mag, x - 1, y - 1, 1'b1));
      end
      if (x == w - 1 && y >= 1) res.push_back(make_result(b, x, y - 1, 1'b0));
      if (y == h - 1) res.push_back(make_result(d, x, y, 1'b0));
      if (res.size() != 0) begin
        res[$].last_of_run = 1'b1;
        if (x == w - 1 && y == h - 1) res[$].frame_end = 1'b1;
      end
      foreach (res[i]) expected_q.push_back(res[i]);
      upper_left_pix = b;
      left_pix       = d;
      line_mem[x]    = d;
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    // compare an accepted result with the oldest expectation
    function void check_result(edge_result_t got);
      edge_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: pixel %0d at (%0d,%0d)", got.out_pixel, got.out_x,
               got.out_y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_pixel", 32'(want.out_pixel), 32'(got.out_pixel));
      compare_field("out_x", 32'(want.out_x), 32'(got.out_x));
      compare_field("out_y", 32'(want.out_y), 32'(got.out_y));
      compare_field("is_edge", 32'(want.is_edge), 32'(got.is_edge));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  edge_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    idle_cycles = 0;
  edge_result_t   seen_res;

  roberts_cross_edge_magnitude #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // extremes show up often so clipping and flat areas get hit
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: check accepted results, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res.out_pixel   = m_axis_tdata[7:0];
      seen_res.out_x       = m_axis_tdata[19:8];
      seen_res.out_y       = m_axis_tdata[31:20];
      seen_res.is_edge     = m_axis_tuser[0];
      seen_res.frame_end   = m_axis_tuser[1];
      seen_res.last_of_run = m_axis_tlast;
      sb.check_result(seen_res);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  // watchdog on cycles where no request of any kind is taken
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_roberts_cross_edge_magnitude failed");
        $finish;
      end
    end
  end

  // one register write, valid stays high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input int unsigned which);
    if (which != WRITE_HEIGHT) cfg_write(REG_FRAME_WIDTH, w);
    if (which != WRITE_WIDTH) cfg_write(REG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one pixel, note it once taken, then maybe idle
  task automatic send_pixel(input logic [7:0] pix);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(pix);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // a pixel with no result may still be in flight after the last result
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drained();
      send_pixel(pick_pixel());
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned w, h, which, count, ppf;
    sent  = 0;
    phase = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 checkerboard of full-swing pixels, zero magnitudes, then wrap into next frame
    set_frame(3, 3, WRITE_BOTH);
    send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd255);
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd0);
    send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd255);
    send_pixel(8'd0);   send_pixel(8'd255);
    wait_idle();

    // zero width taken as one column: no edge values, store pass-through only
    set_frame(0, 2, WRITE_BOTH);
    send_pixel(8'd7); send_pixel(8'd200); send_pixel(8'd255);
    wait_idle();

    // zero height taken as one row, written mid-frame: every pixel passes through
    set_frame(2, 0, WRITE_BOTH);
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd128); send_pixel(8'd1);
    wait_idle();

    // random frames of mostly small sizes, some cut short by a restart
    while (sent < RANDOM_PIX) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0: h = 8191;
        1: h = 0;
        default: h = $urandom_range(1, 6);
      endcase
      which = $urandom_range(0, 4);
      if (which > WRITE_HEIGHT) which = WRITE_BOTH;
      no_idle = ($urandom_range(0, 3) == 0);
      set_frame(w, h, which);
      ppf   = sb.frame_pixels();
      count = ppf * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, ppf);
      if (count > 60) count = $urandom_range(10, 60);
      send_random(count, (phase == 0) ? int'(count / 2) : -1);
      wait_idle();
      sent += count;
      phase++;
    end

    // oversized width and full height, start of a frame each
    no_idle = 1'b0;
    set_frame(8191, 1, WRITE_BOTH);
    send_random(EXTREME_PIX, -1);
    wait_idle();
    set_frame(1, MAX_DIM, WRITE_BOTH);
    send_random(EXTREME_PIX, -1);
    wait_idle();

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_roberts_cross_edge_magnitude passed");
    end else begin
      $display("tb_roberts_cross_edge_magnitude failed");
    end
    $finish;
  end

endmodule

### roberts_cross_edge_magnitude.f
rtl/core/rcem_pkg.sv
rtl/core/rcem_ctrl.sv
rtl/core/rcem_datapath.sv
rtl/core/roberts_cross_edge_magnitude.sv
tb/tb_roberts_cross_edge_magnitude.sv
